// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the derivative line.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define UFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define UFD_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ufd_pkg.sv -----
// Package of the upwind derivative line: widths, defaults, register indexes,
// stencil kinds and the metadata struct. No dependencies.
package ufd_pkg;

    // Fixed field widths
    localparam int LEN_W       = 11;
    localparam int POS_W       = 10;
    localparam int SCALE_W     = 32;
    localparam int IN_SAMPLE_W = 32;
    localparam int VEL_W       = 32;
    localparam int DERIV_W     = 48;
    localparam int Q_W         = DERIV_W + 1;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Parameter defaults
    localparam int PAD_WIDTH_DEF   = 3;
    localparam int MAX_LINE_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 32;

    // Line geometry
    localparam int LINE_LENGTH_MIN = 12;
    localparam int WIN_DEPTH       = 7;
    localparam int WIN_LAG         = 3;

    // Register reset values
    localparam logic [LEN_W-1:0]   LINE_LENGTH_RST   = LEN_W'(16);
    localparam logic [SCALE_W-1:0] SCALE_TWELFTH_RST = SCALE_W'(5461);
    localparam logic [SCALE_W-1:0] SCALE_HALF_RST    = SCALE_W'(32768);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CLOSURE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_CLOSURE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_TWELFTH = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_HALF    = CFG_IDX_W'(4);

    // Stencil shapes over the 7-sample window (w3 is the output position)
    typedef enum logic [2:0] {
        ST_FWD,      // -3w2 -10w3 +18w4 -6w5 +w6, twelfth scale
        ST_BWD,      // -w0 +6w1 -18w2 +10w3 +3w4, twelfth scale
        ST_ONE_FWD,  // -3w3 +4w4 -w5, half scale
        ST_CEN,      // -w2 +w4, half scale
        ST_ONE_BWD   // w1 -4w2 +3w3, half scale
    } t_stencil;

    // Per-result metadata carried down the pipeline
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             last;
    } t_meta;

endpackage

// ----- hw/rtl/ufd_stencil.sv -----
// Integer-coefficient stencil sum over the sample window.
// Depends on ufd_pkg (t_stencil, WIN_DEPTH).
module ufd_stencil #(
    parameter int SAMPLE_BITS = ufd_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] i_win [0:ufd_pkg::WIN_DEPTH-1],
    input  ufd_pkg::t_stencil             i_kind,
    output logic signed [SAMPLE_BITS+5:0] o_sum
);
    localparam int SUM_W = SAMPLE_BITS + 6;

    localparam logic signed [SUM_W-1:0] K3  = SUM_W'(3);
    localparam logic signed [SUM_W-1:0] K4  = SUM_W'(4);
    localparam logic signed [SUM_W-1:0] K6  = SUM_W'(6);
    localparam logic signed [SUM_W-1:0] K10 = SUM_W'(10);
    localparam logic signed [SUM_W-1:0] K18 = SUM_W'(18);

    logic signed [SUM_W-1:0] w [0:ufd_pkg::WIN_DEPTH-1];

    // Sign-extend the window to the sum width
    always_comb begin
        for (int i = 0; i < ufd_pkg::WIN_DEPTH; i++) begin
            w[i] = SUM_W'(i_win[i]);
        end
    end

    // Pick the stencil
    always_comb begin
        case (i_kind)
            ufd_pkg::ST_FWD:
                o_sum = w[6] - K3 * w[2] - K10 * w[3] + K18 * w[4] - K6 * w[5];
            ufd_pkg::ST_BWD:
                o_sum = K6 * w[1] - w[0] - K18 * w[2] + K10 * w[3] + K3 * w[4];
            ufd_pkg::ST_ONE_FWD:
                o_sum = K4 * w[4] - K3 * w[3] - w[5];
            ufd_pkg::ST_CEN:
                o_sum = w[4] - w[2];
            ufd_pkg::ST_ONE_BWD:
                o_sum = w[1] - K4 * w[2] + K3 * w[3];
            default:
                o_sum = '0;
        endcase
    end

endmodule

// ----- hw/rtl/ufd_scale.sv -----
// Scaling pipeline: sum register, magnitude, split multiply, rounding,
// saturation to 48 bits. Depends on ufd_pkg (widths, t_meta).
module ufd_scale #(
    parameter int SAMPLE_BITS = ufd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [SAMPLE_BITS+5:0]       i_sum,
    input  logic [ufd_pkg::SCALE_W-1:0]         i_scale,
    input  ufd_pkg::t_meta                      i_meta,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ufd_pkg::DERIV_W-1:0]         o_deriv,
    output ufd_pkg::t_meta                      o_meta
);
    localparam int SUM_W = SAMPLE_BITS + 6;
    localparam int EXT_W = (SUM_W > 33) ? SUM_W : 33;
    localparam int HI_W  = EXT_W - 32;
    localparam int SC_W  = ufd_pkg::SCALE_W;
    localparam int Q_W   = ufd_pkg::Q_W;
    localparam int D_W   = ufd_pkg::DERIV_W;

    localparam logic [Q_W-1:0] LIM_NEG = Q_W'(1) << (D_W - 1);
    localparam logic [Q_W-1:0] LIM_POS = LIM_NEG - Q_W'(1);

    // Stage valids and load enables
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic ld1, ld2, ld3, ld4, ldo;

    // Stage 1: stencil sum
    logic signed [SUM_W-1:0] r_sum1;
    logic [SC_W-1:0]         r_scale1;
    ufd_pkg::t_meta          r_meta1;
    // Stage 2: magnitude
    logic [SUM_W-1:0]        r_mag2, n_mag2;
    logic                    r_neg2;
    logic [SC_W-1:0]         r_scale2;
    ufd_pkg::t_meta          r_meta2;
    // Stage 3: partial products
    logic [EXT_W-1:0]        m_ext;
    logic [63:0]             r_lo3, n_lo3;
    logic [HI_W+31:0]        r_hi3, n_hi3;
    logic                    r_neg3;
    ufd_pkg::t_meta          r_meta3;
    // Stage 4: rounded quotient
    logic [Q_W-1:0]          r_q4, n_q4;
    logic                    r_ovf4, r_neg4;
    ufd_pkg::t_meta          r_meta4;
    // Output
    logic [D_W-1:0]          r_deriv, n_deriv;
    ufd_pkg::t_meta          r_meta_o;
    logic [D_W-1:0]          q_clamp;

    // Each stage loads when empty or when the next one loads
    assign ldo     = !r_vo || i_ready;
    assign ld4     = !r_v4 || ldo;
    assign ld3     = !r_v3 || ld4;
    assign ld2     = !r_v2 || ld3;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_valid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
            if (ldo) r_vo <= r_v4;
        end
    end

    // Magnitude of the sum
    always_comb begin
        n_mag2 = r_sum1[SUM_W-1] ? $unsigned(-r_sum1) : $unsigned(r_sum1);
    end

    // Split multiply: low 32 bits and the high remainder of the magnitude
    always_comb begin
        m_ext = EXT_W'(r_mag2);
        n_lo3 = 64'(m_ext[31:0]) * 64'(r_scale2);
        n_hi3 = (HI_W + 32)'(m_ext[EXT_W-1:32]) * (HI_W + 32)'(r_scale2);
    end

    // Drop 16 fraction bits, round half away from zero on the magnitude
    always_comb begin
        n_q4 = Q_W'({r_hi3[31:0], 16'b0}) + Q_W'(r_lo3[63:16]) + Q_W'(r_lo3[15]);
    end

    // Saturate and restore the sign
    always_comb begin
        if (r_neg4) begin
            q_clamp = (r_ovf4 || (r_q4 > LIM_NEG)) ? LIM_NEG[D_W-1:0] : r_q4[D_W-1:0];
            n_deriv = D_W'(0) - q_clamp;
        end else begin
            q_clamp = (r_ovf4 || (r_q4 > LIM_POS)) ? LIM_POS[D_W-1:0] : r_q4[D_W-1:0];
            n_deriv = q_clamp;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_sum1   <= i_sum;
            r_scale1 <= i_scale;
            r_meta1  <= i_meta;
        end
        if (ld2) begin
            r_mag2   <= n_mag2;
            r_neg2   <= r_sum1[SUM_W-1];
            r_scale2 <= r_scale1;
            r_meta2  <= r_meta1;
        end
        if (ld3) begin
            r_lo3   <= n_lo3;
            r_hi3   <= n_hi3;
            r_neg3  <= r_neg2;
            r_meta3 <= r_meta2;
        end
        if (ld4) begin
            r_q4    <= n_q4;
            r_ovf4  <= |r_hi3[HI_W+31:32];
            r_neg4  <= r_neg3;
            r_meta4 <= r_meta3;
        end
        if (ldo) begin
            r_deriv  <= n_deriv;
            r_meta_o <= r_meta4;
        end
    end

    assign o_valid = r_vo;
    assign o_deriv = r_deriv;
    assign o_meta  = r_meta_o;

endmodule

// ----- hw/rtl/upwind_fd_derivative_line.sv -----
// Top level of the upwind derivative line: config registers, sample window,
// line counter, stencil selection. Depends on ufd_pkg, ufd_stencil, ufd_scale.
//
// Use: samples of one grid line (padding included) stream in on the slave
// channel, one beat per sample, with the shift velocity of that sample.
// When sample p+3 is taken, the derivative at position p is produced if p is
// an interior position, or position 3 with low-edge closures on; other beats
// only advance the window. The master channel carries the derivative, its
// position and tlast on the last interior position of the line.
// Throughput: one beat per cycle in both directions while the receiver takes
// beats. Each result passes through the registered stages in order: one
// selection stage, one stencil-sum stage, magnitude, split multiply,
// rounding, saturation. A stalled receiver holds the output beat; the
// stages behind it keep filling until all are full, then tready drops.
// Reset empties the pipeline, zeroes the line counter and loads the register
// defaults. Write registers only while no beat is in flight; writes take
// effect at once and do not restart the line.
module upwind_fd_derivative_line #(
    parameter int PAD_WIDTH   = ufd_pkg::PAD_WIDTH_DEF,
    parameter int MAX_LINE    = ufd_pkg::MAX_LINE_DEF,
    parameter int SAMPLE_BITS = ufd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [ufd_pkg::S_TDATA_W-1:0]     i_s_tdata,  // [31:0] sample, [63:32] shift_velocity
    // Master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [ufd_pkg::M_TDATA_W-1:0]     o_m_tdata,  // [47:0] derivative, [57:48] position
    output logic                              o_m_tlast,  // last_of_line
    // Register write port
    input  logic                              i_cfg_wr_en,
    input  logic [ufd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ufd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int LEN_W = ufd_pkg::LEN_W;
    localparam int SC_W  = ufd_pkg::SCALE_W;
    localparam int IN_W  = ufd_pkg::IN_SAMPLE_W;
    localparam int VEL_W = ufd_pkg::VEL_W;
    localparam int SUM_W = SAMPLE_BITS + 6;
    localparam int DEPTH = ufd_pkg::WIN_DEPTH;
    localparam int PAD_M = ufd_pkg::M_TDATA_W - ufd_pkg::DERIV_W - ufd_pkg::POS_W;

    localparam logic [LEN_W-1:0] LAG       = LEN_W'(ufd_pkg::WIN_LAG);
    localparam logic [LEN_W-1:0] LOW_POS_A = LEN_W'(3);
    localparam logic [LEN_W-1:0] LOW_POS_B = LEN_W'(4);
    localparam logic [LEN_W-1:0] LOW_POS_C = LEN_W'(5);

    // Configuration registers
    logic [LEN_W-1:0] r_line_length;
    logic             r_low_closure;
    logic             r_high_closure;
    logic [SC_W-1:0]  r_scale_twelfth;
    logic [SC_W-1:0]  r_scale_half;

    // Line state
    logic signed [SAMPLE_BITS-1:0] r_win [0:DEPTH-1];
    logic [2:0]                    r_flags;   // [2] newest, [0] flag of position p
    logic [LEN_W-1:0]              r_count, n_count;

    // Selection stage
    logic               r_a_valid;
    ufd_pkg::t_stencil  r_a_kind, n_kind;
    logic               r_a_half;
    ufd_pkg::t_meta     r_a_meta, n_meta;

    logic                          accept;
    logic [LEN_W-1:0]              len, ie, pos_p;
    logic [LEN_W:0]                cnt_inc;
    logic                          emit, up, vel_pos, high_zone, low_zone;
    logic signed [SAMPLE_BITS-1:0] new_sample;
    logic signed [SUM_W-1:0]       sum;
    logic                          scale_ready;
    logic [ufd_pkg::DERIV_W-1:0]   deriv;
    ufd_pkg::t_meta                out_meta;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length   <= ufd_pkg::LINE_LENGTH_RST;
            r_low_closure   <= 1'b0;
            r_high_closure  <= 1'b0;
            r_scale_twelfth <= ufd_pkg::SCALE_TWELFTH_RST;
            r_scale_half    <= ufd_pkg::SCALE_HALF_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ufd_pkg::REG_LINE_LENGTH:   r_line_length   <= i_cfg_data[LEN_W-1:0];
                ufd_pkg::REG_LOW_CLOSURE:   r_low_closure   <= i_cfg_data[0];
                ufd_pkg::REG_HIGH_CLOSURE:  r_high_closure  <= i_cfg_data[0];
                ufd_pkg::REG_SCALE_TWELFTH: r_scale_twelfth <= i_cfg_data[SC_W-1:0];
                ufd_pkg::REG_SCALE_HALF:    r_scale_half    <= i_cfg_data[SC_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample sign taken at SAMPLE_BITS
    generate
        if (SAMPLE_BITS <= IN_W) begin : g_narrow
            assign new_sample = $signed(i_s_tdata[SAMPLE_BITS-1:0]);
        end else begin : g_wide
            assign new_sample = $signed(SAMPLE_BITS'(i_s_tdata[IN_W-1:0]));
        end
    endgenerate

    assign vel_pos = !i_s_tdata[IN_W+VEL_W-1] && (|i_s_tdata[IN_W+VEL_W-2:IN_W]);
    assign accept  = i_s_tvalid && o_s_tready;

    // Clamp line length, find interior end and next count
    always_comb begin
        if (r_line_length < LEN_W'(ufd_pkg::LINE_LENGTH_MIN)) begin
            len = LEN_W'(ufd_pkg::LINE_LENGTH_MIN);
        end else if (32'(r_line_length) > 32'(MAX_LINE)) begin
            len = LEN_W'(MAX_LINE);
        end else begin
            len = r_line_length;
        end
        ie      = len - LEN_W'(PAD_WIDTH);
        cnt_inc = {1'b0, r_count} + (LEN_W + 1)'(1);
        n_count = (cnt_inc >= {1'b0, len}) ? '0 : cnt_inc[LEN_W-1:0];
    end

    // Position of the result this beat completes, and whether it emits
    always_comb begin
        pos_p     = r_count - LAG;
        up        = r_flags[0];
        emit      = (r_count >= LAG) &&
                    (((pos_p >= LEN_W'(PAD_WIDTH)) && (pos_p < ie)) ||
                     (r_low_closure && (pos_p == LOW_POS_A)));
        high_zone = r_high_closure && (r_count >= ie) && (pos_p < ie);
        low_zone  = r_low_closure && (pos_p >= LOW_POS_A) && (pos_p <= LOW_POS_C);
        n_meta.pos  = pos_p[ufd_pkg::POS_W-1:0];
        n_meta.last = (pos_p == ie - LEN_W'(1));
    end

    // Choose the stencil; high closures win over low ones
    always_comb begin
        if (high_zone) begin
            if (pos_p == ie - LEN_W'(3)) begin
                n_kind = up ? ufd_pkg::ST_ONE_FWD : ufd_pkg::ST_BWD;
            end else if (pos_p == ie - LEN_W'(2)) begin
                n_kind = up ? ufd_pkg::ST_CEN : ufd_pkg::ST_ONE_BWD;
            end else begin
                n_kind = ufd_pkg::ST_ONE_BWD;
            end
        end else if (low_zone) begin
            if (pos_p == LOW_POS_A) begin
                n_kind = ufd_pkg::ST_ONE_FWD;
            end else if (pos_p == LOW_POS_B) begin
                n_kind = up ? ufd_pkg::ST_ONE_FWD : ufd_pkg::ST_CEN;
            end else begin
                n_kind = up ? ufd_pkg::ST_FWD : ufd_pkg::ST_ONE_BWD;
            end
        end else begin
            n_kind = up ? ufd_pkg::ST_FWD : ufd_pkg::ST_BWD;
        end
    end

    // Hold the window while the selected item waits for the sum stage
    assign o_s_tready = !r_a_valid || scale_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (accept) r_count <= n_count;
            if (o_s_tready) r_a_valid <= accept && emit;
        end
    end

    // Advance window and velocity flags, capture the selection
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[DEPTH-1] <= new_sample;
            r_flags        <= {vel_pos, r_flags[2:1]};
        end
        if (o_s_tready) begin
            r_a_kind <= n_kind;
            r_a_half <= (n_kind inside {ufd_pkg::ST_ONE_FWD, ufd_pkg::ST_CEN,
                                        ufd_pkg::ST_ONE_BWD});
            r_a_meta <= n_meta;
        end
    end

    ufd_stencil #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_stencil (
        .i_win  (r_win),
        .i_kind (r_a_kind),
        .o_sum  (sum)
    );

    ufd_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .o_ready (scale_ready),
        .i_sum   (sum),
        .i_scale (r_a_half ? r_scale_half : r_scale_twelfth),
        .i_meta  (r_a_meta),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_deriv (deriv),
        .o_meta  (out_meta)
    );

    // Pack the output beat
    assign o_m_tdata = {PAD_M'(0), out_meta.pos, deriv};
    assign o_m_tlast = out_meta.last;

endmodule

// ----- hw/rtl/ufd_checker.sv -----
// Port-level checker for the upwind derivative line, bound to the top level.
// Depends on assert_macros.svh and ufd_pkg.
`include "assert_macros.svh"

module ufd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [ufd_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [ufd_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input logic                              o_m_tlast
);
    localparam int PAD_LO = ufd_pkg::DERIV_W + ufd_pkg::POS_W;

    // A stalled output beat holds
    `UFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "output beat changed under stall")

    // A waiting input beat holds until taken
    `UFD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_s_tvalid && !o_s_tready,
        i_s_tvalid && $stable(i_s_tdata), "input beat changed under stall")

    // Input side never blocks while the output register can drain
    `UFD_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_m_tvalid || i_m_tready,
        o_s_tready, "input blocked with a free output stage")

    // Reset empties the output
    `UFD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_tvalid, "output valid after reset")

    // Pad bits above the position stay zero
    `UFD_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, o_m_tvalid,
        o_m_tdata[ufd_pkg::M_TDATA_W-1:PAD_LO] == '0, "nonzero tdata padding")

endmodule

bind upwind_fd_derivative_line ufd_checker u_ufd_checker (.*);
